// ===== src/escape_sequence_decoder_defines.svh =====
// Assertion macros shared by the decoder.
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// Implication in the same cycle, checked outside reset.
`define ESD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, checked outside reset.
`define ESD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/esd_pkg.sv =====
package esd_pkg;

    typedef enum logic [1:0] {
        PH_PLAIN  = 2'd0,
        PH_BSLASH = 2'd1,
        PH_HEX1   = 2'd2,
        PH_HEX2   = 2'd3
    } phase_t;

    localparam logic [7:0] CH_TERM    = 8'h00;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [7:0] LIMIT_RESET = 8'd255;

    // Register indexes on the configuration port
    localparam logic REG_OUT_LIMIT = 1'b0;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } nibble_t;

    function automatic nibble_t nibble_of(input logic [7:0] c);
        nibble_t r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.value = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.value = 4'(c - 8'h61 + 8'd10);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== src/escape_sequence_decoder.sv =====
// Backslash escape decoder, one character per transaction.
// Slave stream s_*: one character per transaction in s_tdata, zero ends a string.
// Master stream m_*: one result per character; m_tlast marks the terminator's
// result, which carries the failure flag and the final byte count of the string.
// APB port: register 0 (byte address 0) is out_limit, the most bytes decoded per
// string; reads return it. Write it only while the block is idle.
// The result of an accepted character is registered and presented on m_* in the
// next cycle. Throughput is one character per cycle while the receiver does not
// stall, set by the single output register; a new character is taken while the
// previous result is being taken.
// When the receiver stalls, the output register holds its result and s_tready
// drops until it drains.
// Reset (aresetn low, synchronous) empties the output register, returns the
// decoder to plain text with a zero count and sets out_limit to 255.
`include "escape_sequence_decoder_defines.svh"

module escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [7:0] ch
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // m_tdata: [7:0] out_byte, [8] byte_valid, [9] failed, [17:10] out_count,
    // [23:18] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    phase_t     phase_reg, phase_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic       error_seen_reg, error_seen_next;
    logic [7:0] out_limit_reg;

    logic       m_valid_reg;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       byte_valid_reg, byte_valid_next;
    logic       finished_reg, finished_next;
    logic       failed_reg, failed_next;
    logic [7:0] out_count_reg, out_count_next;

    logic       in_accept;
    logic       is_term;
    logic       active;
    logic       step_err;
    nibble_t    nib;

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign is_term   = (s_tdata == CH_TERM);
    assign active    = !error_seen_reg && (byte_count_reg < out_limit_reg);
    assign nib       = nibble_of(s_tdata);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        step_err   = 1'b0;
        if (is_term) begin
            phase_next = PH_PLAIN;
        end else if (active) begin
            unique case (phase_reg)
                PH_PLAIN: begin
                    if (s_tdata == CH_BSLASH) begin
                        phase_next = PH_BSLASH;
                    end
                end
                PH_BSLASH: begin
                    priority if (s_tdata == CH_X) begin
                        phase_next = PH_HEX1;
                    end else if (s_tdata == CH_N || s_tdata == CH_BSLASH) begin
                        phase_next = PH_PLAIN;
                    end else begin
                        step_err = 1'b1;
                    end
                end
                PH_HEX1: begin
                    if (nib.ok) begin
                        phase_next = PH_HEX2;
                    end else begin
                        step_err = 1'b1;
                    end
                end
                PH_HEX2: begin
                    if (nib.ok) begin
                        phase_next = PH_PLAIN;
                    end else begin
                        step_err = 1'b1;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // Decoded byte, counters and result fields
    always_comb begin
        out_byte_next    = 8'd0;
        byte_valid_next  = 1'b0;
        high_nibble_next = high_nibble_reg;
        error_seen_next  = error_seen_reg || step_err;
        finished_next    = is_term;
        failed_next      = 1'b0;
        if (is_term) begin
            failed_next      = error_seen_reg || (phase_reg != PH_PLAIN);
            high_nibble_next = 4'd0;
            error_seen_next  = 1'b0;
        end else if (active) begin
            unique case (phase_reg)
                PH_PLAIN: begin
                    if (s_tdata != CH_BSLASH) begin
                        out_byte_next   = s_tdata;
                        byte_valid_next = 1'b1;
                    end
                end
                PH_BSLASH: begin
                    if (s_tdata == CH_N) begin
                        out_byte_next   = CH_NEWLINE;
                        byte_valid_next = 1'b1;
                    end else if (s_tdata == CH_BSLASH) begin
                        out_byte_next   = CH_BSLASH;
                        byte_valid_next = 1'b1;
                    end
                end
                PH_HEX1: begin
                    if (nib.ok) begin
                        high_nibble_next = nib.value;
                    end
                end
                PH_HEX2: begin
                    if (nib.ok) begin
                        out_byte_next    = {high_nibble_reg, nib.value};
                        byte_valid_next  = 1'b1;
                        high_nibble_next = 4'd0;
                    end
                end
                default: out_byte_next = 8'd0;
            endcase
        end
        if (is_term) begin
            out_count_next  = byte_count_reg;
            byte_count_next = 8'd0;
        end else begin
            byte_count_next = byte_count_reg + {7'd0, byte_valid_next};
            out_count_next  = byte_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_PLAIN;
            high_nibble_reg <= 4'd0;
            byte_count_reg  <= 8'd0;
            error_seen_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (in_accept) begin
                phase_reg       <= phase_next;
                high_nibble_reg <= high_nibble_next;
                byte_count_reg  <= byte_count_next;
                error_seen_reg  <= error_seen_next;
                m_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg     <= 1'b0;
            end
        end
    end

    // Result register: load on every accepted character
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_byte_reg   <= out_byte_next;
            byte_valid_reg <= byte_valid_next;
            finished_reg   <= finished_next;
            failed_reg     <= failed_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = finished_reg;
    assign m_tdata  = {6'd0, out_count_reg, failed_reg, byte_valid_reg, out_byte_reg};

    // Configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_OUT_LIMIT) begin
            out_limit_reg <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUT_LIMIT) ? {24'd0, out_limit_reg} : 32'd0;

    `ESD_ASSERT_NEXT(a_term_clears, aclk, aresetn, in_accept && is_term,
        phase_reg == PH_PLAIN && byte_count_reg == 8'd0 && !error_seen_reg,
        "state not cleared after terminator")

    `ESD_ASSERT_SAME(a_last_no_byte, aclk, aresetn, m_valid_reg && finished_reg,
        !byte_valid_reg, "terminator result carries a byte")

    `ESD_ASSERT_NEXT(a_count_step, aclk, aresetn, in_accept && byte_valid_next,
        byte_count_reg == $past(byte_count_reg) + 8'd1, "byte count did not advance")

    `ESD_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_valid_reg, s_tready,
        "input stalled with empty output register")

endmodule
